// ===== rtl/core/bhpq_pkg.sv =====
// shared types and constants for the binary heap priority queue
// used by bhpq_ctrl, bhpq_dpath and binary_heap_priority_queue_unit
`timescale 1ns / 1ps

package bhpq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int OCC_W    = 5;

   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_EXTRACT = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic                    kind;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] root_value;
      logic [1:0]              status;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_NONE     = 2'd0,
      RD_PARENT   = 2'd1,
      RD_ENDS     = 2'd2,
      RD_CHILDREN = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE   = 2'd0,
      WR_PARENT = 2'd1,
      WR_CHILD  = 2'd2,
      WR_HOLE   = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic       start_insert;
      logic       start_extract;
      logic       reject_full;
      logic       reject_empty;
      logic       load_ends;
      logic       emit;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic left_out;
      logic up_above;
      logic down_above;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/bhpq_dpath.sv =====
// heap datapath: entry memory, count, sift position, held value and result register
// depends on bhpq_pkg
`timescale 1ns / 1ps

module bhpq_dpath (
   input  logic              clock,
   input  logic              reset,
   input  bhpq_pkg::cmd_type cmd,
   output bhpq_pkg::stat_type stat,
   input  bhpq_pkg::req_type req_data,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bhpq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = bhpq_pkg::IDX_W;
   localparam int CNT_W = bhpq_pkg::CNT_W;
   localparam int VAL_W = bhpq_pkg::VAL_W;
   localparam int LFT_W = IDX_W + 1;

   logic [VAL_W-1:0] heap_ff [bhpq_pkg::CAPACITY];
   logic [VAL_W-1:0] rd0_ff, rd1_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [VAL_W-1:0] hole_ff, hole_in;
   logic [VAL_W-1:0] root_ff, root_in;
   logic [1:0]       stat_ff, stat_in;
   logic             order_ff;
   logic             rsp_valid_ff;
   bhpq_pkg::rsp_type rsp_data_ff;

   logic [IDX_W-1:0] parent;
   logic [LFT_W-1:0] count_ext, left_wide, right_wide;
   logic             right_ok;
   logic             pick_right;
   logic [VAL_W-1:0] pick_val;
   logic [IDX_W-1:0] pick_idx;
   logic [IDX_W-1:0] rd0_addr, rd1_addr;
   logic             mem_we;
   logic [VAL_W-1:0] mem_wdata;

   function automatic logic ranks_above(input logic [VAL_W-1:0] a,
                                        input logic [VAL_W-1:0] b,
                                        input logic             max_order);
      if (max_order)
         return $signed(a) > $signed(b);
      return $signed(a) < $signed(b);
   endfunction

   assign parent     = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign count_ext  = LFT_W'(count_ff);
   assign left_wide  = {pos_ff, 1'b1};
   assign right_wide = left_wide + LFT_W'(1);
   assign right_ok   = right_wide < count_ext;

   assign pick_right = right_ok && ranks_above(rd1_ff, rd0_ff, order_ff);
   assign pick_val   = pick_right ? rd1_ff : rd0_ff;
   assign pick_idx   = pick_right ? right_wide[IDX_W-1:0] : left_wide[IDX_W-1:0];

   assign stat.full       = count_ff == CNT_W'(bhpq_pkg::CAPACITY);
   assign stat.empty      = count_ff == '0;
   assign stat.pos_zero   = pos_ff == '0;
   assign stat.left_out   = left_wide >= count_ext;
   assign stat.up_above   = ranks_above(hole_ff, rd0_ff, order_ff);
   assign stat.down_above = ranks_above(pick_val, hole_ff, order_ff);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // read address selection
   always_comb begin
      rd0_addr = '0;
      rd1_addr = '0;
      case (cmd.rd_sel)
         bhpq_pkg::RD_PARENT: begin
            rd0_addr = parent;
         end
         bhpq_pkg::RD_ENDS: begin
            rd0_addr = '0;
            rd1_addr = count_ff[IDX_W-1:0];
         end
         bhpq_pkg::RD_CHILDREN: begin
            rd0_addr = left_wide[IDX_W-1:0];
            rd1_addr = right_ok ? right_wide[IDX_W-1:0] : left_wide[IDX_W-1:0];
         end
         default: begin
            rd0_addr = '0;
            rd1_addr = '0;
         end
      endcase
   end

   always_comb begin
      mem_we    = 1'b1;
      mem_wdata = hole_ff;
      pos_in    = pos_ff;
      case (cmd.wr_sel)
         bhpq_pkg::WR_PARENT: begin
            mem_wdata = rd0_ff;
            pos_in    = parent;
         end
         bhpq_pkg::WR_CHILD: begin
            mem_wdata = pick_val;
            pos_in    = pick_idx;
         end
         bhpq_pkg::WR_HOLE: begin
            mem_wdata = hole_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
      if (cmd.start_insert)
         pos_in = count_ff[IDX_W-1:0];
      if (cmd.load_ends)
         pos_in = '0;
   end

   always_comb begin
      count_in = count_ff;
      hole_in  = hole_ff;
      root_in  = root_ff;
      stat_in  = stat_ff;
      if (cmd.start_insert) begin
         count_in = count_ff + CNT_W'(1);
         hole_in  = req_data.value;
         root_in  = '0;
         stat_in  = bhpq_pkg::STAT_OK;
      end
      if (cmd.start_extract) begin
         count_in = count_ff - CNT_W'(1);
         stat_in  = bhpq_pkg::STAT_OK;
      end
      if (cmd.reject_full) begin
         root_in = '0;
         stat_in = bhpq_pkg::STAT_FULL;
      end
      if (cmd.reject_empty) begin
         root_in = '0;
         stat_in = bhpq_pkg::STAT_EMPTY;
      end
      if (cmd.load_ends) begin
         root_in = rd0_ff;
         hole_in = rd1_ff;
      end
   end

   // entry memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (mem_we)
         heap_ff[pos_ff] <= mem_wdata;
      rd0_ff <= heap_ff[rd0_addr];
      rd1_ff <= heap_ff[rd1_addr];
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      hole_ff <= hole_in;
      root_ff <= root_in;
      stat_ff <= stat_in;
      if (cmd.emit) begin
         rsp_data_ff.root_value <= root_ff;
         rsp_data_ff.status     <= stat_ff;
         rsp_data_ff.occupancy  <= bhpq_pkg::OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_write_enable)
            order_ff <= csr_write_data;
         if (cmd.emit)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded while previous item still stalled");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (!cmd.start_insert && !cmd.start_extract) |=> $stable(count_ff))
      else $error("entry count changed outside item start");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.start_insert |=> (count_ff == $past(count_ff) + CNT_W'(1)) &&
                           (count_ff <= CNT_W'(bhpq_pkg::CAPACITY)))
      else $error("insert did not grow heap within capacity");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      cmd.reject_full |-> count_ff == CNT_W'(bhpq_pkg::CAPACITY))
      else $error("insert rejected while heap not full");
`endif

endmodule

// ===== rtl/core/bhpq_ctrl.sv =====
// heap controller: sequences insert sift-up and extract sift-down
// depends on bhpq_pkg
`timescale 1ns / 1ps

module bhpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_kind,
   output logic               req_stall,
   input  bhpq_pkg::stat_type stat,
   output bhpq_pkg::cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_UP_RD  = 8'b0000_0010,
      ST_UP_CMP = 8'b0000_0100,
      ST_EX_RD  = 8'b0000_1000,
      ST_EX_LD  = 8'b0001_0000,
      ST_DN_RD  = 8'b0010_0000,
      ST_DN_CMP = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == bhpq_pkg::KIND_INSERT) begin
                  if (stat.full) begin
                     cmd.reject_full = 1'b1;
                     state_in        = ST_DONE;
                  end else begin
                     cmd.start_insert = 1'b1;
                     state_in         = ST_UP_RD;
                  end
               end else begin
                  if (stat.empty) begin
                     cmd.reject_empty = 1'b1;
                     state_in         = ST_DONE;
                  end else begin
                     cmd.start_extract = 1'b1;
                     state_in          = ST_EX_RD;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (stat.pos_zero) begin
               cmd.wr_sel = bhpq_pkg::WR_HOLE;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_sel = bhpq_pkg::RD_PARENT;
               state_in   = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_above) begin
               cmd.wr_sel = bhpq_pkg::WR_PARENT;
               state_in   = ST_UP_RD;
            end else begin
               cmd.wr_sel = bhpq_pkg::WR_HOLE;
               state_in   = ST_DONE;
            end
         end
         ST_EX_RD: begin
            cmd.rd_sel = bhpq_pkg::RD_ENDS;
            state_in   = ST_EX_LD;
         end
         ST_EX_LD: begin
            cmd.load_ends = 1'b1;
            state_in      = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (stat.left_out) begin
               cmd.wr_sel = bhpq_pkg::WR_HOLE;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_sel = bhpq_pkg::RD_CHILDREN;
               state_in   = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (stat.down_above) begin
               cmd.wr_sel = bhpq_pkg::WR_CHILD;
               state_in   = ST_DN_RD;
            end else begin
               cmd.wr_sel = bhpq_pkg::WR_HOLE;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.start_insert, cmd.start_extract,
                  cmd.reject_full, cmd.reject_empty}) <= 1)
      else $error("more than one item start in a cycle");

   a_start_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_insert || cmd.start_extract || cmd.reject_full || cmd.reject_empty)
         |-> (req_valid && !req_stall))
      else $error("item started without acceptance");

   a_emit_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !req_stall)
      else $error("controller not idle after result");
`endif

endmodule

// ===== rtl/core/binary_heap_priority_queue_unit.sv =====
// binary heap priority queue of signed 32-bit values, min or max order
// top level: joins bhpq_ctrl and bhpq_dpath; depends on bhpq_pkg
// -----------------------------------------------------------------------------
// req channel: req_valid / req_stall / req_data {kind, value}. kind 0 inserts
//   value, kind 1 extracts the root. One item is worked on at a time; req_stall
//   is high from acceptance until the item's result is loaded into rsp.
// rsp channel: rsp_valid / rsp_stall / rsp_data {root_value, status, occupancy},
//   exactly one result per item, held in an output register.
// csr: csr_write_enable / csr_write_data set order_max (0 min, 1 max); the user
//   must write it only while idle, the block itself does not enforce this.
// sifting: each heap level takes a registered memory read, then a compare and
//   move, on the single entry memory; with 16 entries at most 4 swaps up and 3
//   down. Rejected items (full insert, empty extract) skip the sift and go
//   straight to the result.
// a new item is accepted while the previous result waits in rsp; when rsp_stall
//   holds the result, the finished next item waits until rsp is free.
// reset (synchronous, active high) empties the heap, sets min order and drops
//   any pending result; no memory clearing is needed.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_heap_priority_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bhpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bhpq_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   bhpq_pkg::cmd_type  cmd;
   bhpq_pkg::stat_type stat;

   bhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bhpq_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

// ===== tb/tb_binary_heap_priority_queue_unit.sv =====
// self-checking testbench for binary_heap_priority_queue_unit: directed and random heap
// operations in both orders, checked against a local model of the heap; depends on bhpq_pkg
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue_unit;

   localparam int CAPACITY = bhpq_pkg::CAPACITY;
   localparam int IDX_W    = bhpq_pkg::IDX_W;
   localparam int VAL_W    = bhpq_pkg::VAL_W;
   localparam int OCC_W    = bhpq_pkg::OCC_W;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bhpq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bhpq_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data = 1'b0;

   // heap model state
   logic signed [VAL_W-1:0] heap_mem [CAPACITY];
   int unsigned             heap_count = 0;
   bit                      order_max_q = 1'b0;

   bhpq_pkg::req_type heap_ops_q [$];
   bhpq_pkg::rsp_type op_results_q [$];

   int unsigned tx_idle_pct = 13;
   int unsigned rx_idle_pct = 13;
   int unsigned hold_left = 0;
   int unsigned fail_count = 0;
   int unsigned items_taken = 0;
   int unsigned results_seen = 0;
   int unsigned full_seen = 0;
   int unsigned empty_seen = 0;

   binary_heap_priority_queue_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic bit ranks_higher(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
      return order_max_q ? (a > b) : (a < b);
   endfunction

   function automatic void swap_slots(int i, int j);
      logic signed [VAL_W-1:0] tmp;
      tmp = heap_mem[IDX_W'(i)];
      heap_mem[IDX_W'(i)] = heap_mem[IDX_W'(j)];
      heap_mem[IDX_W'(j)] = tmp;
   endfunction

   function automatic bhpq_pkg::rsp_type heap_apply(bhpq_pkg::req_type it);
      bhpq_pkg::rsp_type res;
      int                pos;
      int                parent;
      int                left;
      int                pick;
      res = '0;
      res.status = bhpq_pkg::STAT_OK;
      if (it.kind == bhpq_pkg::KIND_INSERT) begin
         if (heap_count >= CAPACITY) begin
            res.status = bhpq_pkg::STAT_FULL;
         end else begin
            heap_mem[IDX_W'(heap_count)] = it.value;
            pos = heap_count;
            heap_count++;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (!ranks_higher(heap_mem[IDX_W'(pos)], heap_mem[IDX_W'(parent)]))
                  break;
               swap_slots(pos, parent);
               pos = parent;
            end
         end
      end else begin
         if (heap_count == 0) begin
            res.status = bhpq_pkg::STAT_EMPTY;
         end else begin
            res.root_value = heap_mem[0];
            heap_count--;
            heap_mem[0] = heap_mem[IDX_W'(heap_count)];
            pos = 0;
            while (1) begin
               left = 2 * pos + 1;
               if (left >= heap_count)
                  break;
               pick = left;
               if (left + 1 < heap_count &&
                   ranks_higher(heap_mem[IDX_W'(left + 1)], heap_mem[IDX_W'(left)]))
                  pick = left + 1;
               if (!ranks_higher(heap_mem[IDX_W'(pick)], heap_mem[IDX_W'(pos)]))
                  break;
               swap_slots(pos, pick);
               pos = pick;
            end
         end
      end
      res.occupancy = heap_count[OCC_W-1:0];
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            op_results_q.push_back(heap_apply(req_data));
            items_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (heap_ops_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= heap_ops_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bhpq_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (op_results_q.size() == 0) begin
               $display("%0t: unexpected item, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = op_results_q.pop_front();
               if (want.status == bhpq_pkg::STAT_FULL)
                  full_seen++;
               if (want.status == bhpq_pkg::STAT_EMPTY)
                  empty_seen++;
               if (rsp_data.root_value !== want.root_value) begin
                  $display("%0t: root_value expected %0d actual %0d", $time,
                           want.root_value, rsp_data.root_value);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d", $time,
                           want.occupancy, rsp_data.occupancy);
                  fail_count++;
               end
            end
            // long hold-off so the block backs up into its input
            if (results_seen == 100)
               hold_left = 300;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   task automatic push_op(logic kind, logic signed [VAL_W-1:0] value);
      bhpq_pkg::req_type it;
      it.kind  = kind;
      it.value = value;
      heap_ops_q.push_back(it);
   endtask

   task automatic wait_drained();
      while (heap_ops_q.size() != 0 || req_valid || op_results_q.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_order(bit v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      order_max_q = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2, 3:    return $signed($urandom_range(7)) - 4;
         default: return $signed($urandom);
      endcase
   endfunction

   // runs of mostly inserts or mostly extracts so the heap swings between full and empty
   task automatic queue_random(int n);
      bit filling;
      int run;
      int roll;
      filling = 1'b1;
      run = 0;
      for (int i = 0; i < n; i++) begin
         if (run == 0) begin
            filling = 1'($urandom_range(1));
            run = $urandom_range(30, 4);
         end
         run--;
         roll = $urandom_range(99);
         if (roll >= 90)
            push_op(1'($urandom_range(1)), pick_value());
         else if (filling)
            push_op(roll < 15 ? bhpq_pkg::KIND_EXTRACT : bhpq_pkg::KIND_INSERT, pick_value());
         else
            push_op(roll < 15 ? bhpq_pkg::KIND_INSERT : bhpq_pkg::KIND_EXTRACT, pick_value());
      end
   endtask

   initial begin
      logic signed [VAL_W-1:0] fill_vals [16];
      bit                      phase_order [4];
      fill_vals = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 5, 5, -5,
                    100, -100, 32'sh7fffffff, 32'sh80000000, 42, 42, -2, 3};
      phase_order = '{1'b0, 1'b1, 1'b0, 1'b1};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty extract, fill to full, overflow, partial drain
      push_op(bhpq_pkg::KIND_EXTRACT, 32'sh7fffffff);
      foreach (fill_vals[i])
         push_op(bhpq_pkg::KIND_INSERT, fill_vals[i]);
      push_op(bhpq_pkg::KIND_INSERT, 32'sh12345678);
      repeat (4) push_op(bhpq_pkg::KIND_EXTRACT, -1);
      wait_drained();

      // order flips while entries remain, then drain past empty
      write_order(1'b1);
      @(negedge clock);
      repeat (13) push_op(bhpq_pkg::KIND_EXTRACT, 32'sh80000000);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         write_order(phase_order[2'(p)]);
         @(negedge clock);
         tx_idle_pct = (p == 1) ? 0 : 13;
         rx_idle_pct = (p == 1) ? 0 : 13;
         queue_random(300);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d items, %0d results (%0d full inserts, %0d empty extracts)",
               items_taken, results_seen, full_seen, empty_seen);
      $display("both orders, order changes with entries held, long output hold-off");
      if (fail_count == 0)
         $display("PASS binary_heap_priority_queue_unit");
      else
         $display("FAIL binary_heap_priority_queue_unit");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL binary_heap_priority_queue_unit");
      $finish;
   end

endmodule

// ===== binary_heap_priority_queue_unit.f =====
rtl/core/bhpq_pkg.sv
rtl/core/bhpq_dpath.sv
rtl/core/bhpq_ctrl.sv
rtl/core/binary_heap_priority_queue_unit.sv
tb/tb_binary_heap_priority_queue_unit.sv
